// ----- hw/rtl/tpps_pkg.sv -----
package tpps_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_CLOCK_HZ       = 2'd0;
    localparam logic [1:0] REG_MAX_REQUEST_HZ = 2'd1;
    localparam logic [1:0] REG_MIN_PERIOD     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [31:0] CLOCK_HZ_RST       = 32'd72000000;
    localparam logic [31:0] MAX_REQUEST_HZ_RST = 32'd720000;
    localparam logic [15:0] MIN_PERIOD_RST     = 16'd1000;

    // Divider operand selection
    localparam logic [1:0] DIV_CLK_BY_FREQ = 2'd0;
    localparam logic [1:0] DIV_CLK_BY_PRE  = 2'd1;
    localparam logic [1:0] DIV_TMP_BY_FREQ = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_req;
        logic       div_start;
        logic [1:0] div_sel;
        logic       cap_pre;
        logic       cap_tmp;
        logic       cap_per;
        logic       out_load;
        logic       out_fail;
    } tpps_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic freq_zero;
        logic pre_ok;
        logic div_busy;
        logic div_done;
        logic out_busy;
    } tpps_stat_t;

endpackage

// ----- hw/rtl/tpps_div.sv -----
module tpps_div
    import tpps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] diff;

    // One restoring step: shift in the next dividend bit and try a subtract
    always_comb begin
        trial     = {rem_reg, quo_reg[31]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[32]) begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hw/rtl/tpps_dp.sv -----
module tpps_dp
    import tpps_pkg::*;
#(
    parameter int COUNTER_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic [31:0] s_requested_hz,
    input  tpps_cmd_t   cmd,
    output tpps_stat_t  stat,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [15:0] m_prescaler,
    output logic [15:0] m_period
);

    localparam logic [32:0] LIMIT = (33'd1 << COUNTER_BITS) - 33'd1;

    logic [31:0] clock_hz_reg;
    logic [31:0] max_req_reg;
    logic [15:0] min_per_reg;
    logic [31:0] freq_reg;
    logic [32:0] pre_reg;
    logic [31:0] tmp_reg;
    logic [31:0] per_reg;
    logic        out_valid_reg;
    logic        found_reg;
    logic [15:0] out_pre_reg;
    logic [15:0] out_per_reg;

    logic [31:0] freq_clamped;
    logic [31:0] div_a;
    logic [31:0] div_b;
    logic [31:0] div_q;
    logic        div_busy;
    logic        div_done;
    logic        per_ok;
    logic        found;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= CLOCK_HZ_RST;
            max_req_reg  <= MAX_REQUEST_HZ_RST;
            min_per_reg  <= MIN_PERIOD_RST;
        end else if (cfg_wen) begin
            case (cfg_addr)
                REG_CLOCK_HZ:       clock_hz_reg <= cfg_wdata;
                REG_MAX_REQUEST_HZ: max_req_reg  <= cfg_wdata;
                REG_MIN_PERIOD:     min_per_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Clamp the request to the configured maximum
    assign freq_clamped = (s_requested_hz >= max_req_reg) ? max_req_reg : s_requested_hz;

    // Divider operand selection
    always_comb begin
        case (cmd.div_sel)
            DIV_CLK_BY_FREQ: begin
                div_a = clock_hz_reg;
                div_b = freq_reg;
            end
            DIV_CLK_BY_PRE: begin
                div_a = clock_hz_reg;
                div_b = pre_reg[31:0];
            end
            DIV_TMP_BY_FREQ: begin
                div_a = tmp_reg;
                div_b = freq_reg;
            end
            default: begin
                div_a = clock_hz_reg;
                div_b = freq_reg;
            end
        endcase
    end

    tpps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Working registers: clamped request, prescaler, intermediate, period
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            freq_reg <= freq_clamped;
        end
        if (cmd.cap_pre) begin
            pre_reg <= {1'b0, div_q >> COUNTER_BITS} + 33'd1;
        end
        if (cmd.cap_tmp) begin
            tmp_reg <= div_q;
        end
        if (cmd.cap_per) begin
            per_reg <= div_q;
        end
    end

    // Period range check
    assign per_ok = (per_reg >= {16'd0, min_per_reg}) && ({1'b0, per_reg} <= LIMIT);
    assign found  = !cmd.out_fail && per_ok;

    // Output register, holds while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            found_reg   <= found;
            out_pre_reg <= found ? pre_reg[15:0] : 16'd0;
            out_per_reg <= found ? per_reg[15:0] : 16'd0;
        end
    end

    assign stat.freq_zero = (freq_reg == 32'd0);
    assign stat.pre_ok    = (pre_reg <= LIMIT);
    assign stat.div_busy  = div_busy;
    assign stat.div_done  = div_done;
    assign stat.out_busy  = out_valid_reg && !m_ready;

    assign m_valid     = out_valid_reg;
    assign m_found     = found_reg;
    assign m_prescaler = out_pre_reg;
    assign m_period    = out_per_reg;

endmodule

// ----- hw/rtl/tpps_ctrl.sv -----
module tpps_ctrl
    import tpps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  tpps_stat_t stat,
    output tpps_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHK0   = 3'd1;
    localparam logic [2:0] S_WAIT1  = 3'd2;
    localparam logic [2:0] S_CHK1   = 3'd3;
    localparam logic [2:0] S_WAIT2  = 3'd4;
    localparam logic [2:0] S_START3 = 3'd5;
    localparam logic [2:0] S_WAIT3  = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       fail_reg, fail_next;

    // Sequencer over the three divisions
    always_comb begin
        state_next = state_reg;
        fail_next  = fail_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    fail_next    = 1'b0;
                    state_next   = S_CHK0;
                end
            end
            S_CHK0: begin
                if (stat.freq_zero) begin
                    fail_next  = 1'b1;
                    state_next = S_FIN;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_CLK_BY_FREQ;
                    state_next    = S_WAIT1;
                end
            end
            S_WAIT1: begin
                if (stat.div_done) begin
                    cmd.cap_pre = 1'b1;
                    state_next  = S_CHK1;
                end
            end
            S_CHK1: begin
                if (!stat.pre_ok) begin
                    fail_next  = 1'b1;
                    state_next = S_FIN;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_CLK_BY_PRE;
                    state_next    = S_WAIT2;
                end
            end
            S_WAIT2: begin
                if (stat.div_done) begin
                    cmd.cap_tmp = 1'b1;
                    state_next  = S_START3;
                end
            end
            S_START3: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_TMP_BY_FREQ;
                state_next    = S_WAIT3;
            end
            S_WAIT3: begin
                if (stat.div_done) begin
                    cmd.cap_per = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_FIN: begin
                cmd.out_fail = fail_reg;
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fail_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fail_reg  <= fail_next;
        end
    end

    // A division is never started over one in flight
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !stat.div_busy)
        else $error("divider started while busy");

    // A result never overwrites one the receiver has not taken
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !stat.out_busy)
        else $error("output register overwritten");

    // Divider completion only arrives while the sequencer waits for it
    a_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |->
            (state_reg == S_WAIT1 || state_reg == S_WAIT2 || state_reg == S_WAIT3))
        else $error("divider done outside a wait state");

endmodule

// ----- hw/rtl/timer_prescaler_period_solver.sv -----
// Timer prescaler and period solver.
// Input channel s_valid/s_ready carries a requested tick frequency in Hz;
// result channel m_valid/m_ready returns found, prescaler and period, one
// result per request. The request is clamped to max_request_hz, then the
// smallest prescaler whose period fits the counter is checked against
// min_period. Unfit or zero requests return found=0 with zero fields.
// Configuration: cfg_wen writes cfg_wdata into register cfg_addr
// (0 clock_hz, 1 max_request_hz, 2 min_period) at the clock edge; write
// only while no request is in flight.
// A full request runs all three 32-step divisions on the one shared
// radix-2 divider; requests rejected early (zero frequency, or prescaler
// too large) skip the remaining divisions. One request is in work at a
// time and the next one is accepted the cycle after the result is loaded.
// The result sits in an output register; a new request is accepted while it
// waits, and a finished result is held until m_ready takes the old one.
// Reset (aresetn low, synchronous) restores the register defaults and drops
// any request in work and any pending result.
module timer_prescaler_period_solver
    import tpps_pkg::*;
#(
    parameter int COUNTER_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_requested_hz,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [15:0] m_prescaler,
    output logic [15:0] m_period
);

    tpps_cmd_t  cmd;
    tpps_stat_t stat;

    tpps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tpps_dp #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wen        (cfg_wen),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_requested_hz (s_requested_hz),
        .cmd            (cmd),
        .stat           (stat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_prescaler    (m_prescaler),
        .m_period       (m_period)
    );

endmodule
